// File: rtl/secded_pkg.sv
package secded_pkg;

    localparam int CODE_BITS  = 72;
    localparam int CHECK_BITS = 8;
    localparam int DATA_BITS  = 64;
    localparam int POS_BITS   = 7;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_CORRECTED     = 2'd1,
        STATUS_UNCORRECTABLE = 2'd2
    } status_t;

    typedef struct packed {
        logic [DATA_BITS-1:0]  data_in;
        logic [CHECK_BITS-1:0] check_in;
    } in_t;

    typedef struct packed {
        logic [DATA_BITS-1:0]  data_out;
        logic [CHECK_BITS-1:0] check_out;
        status_t               status;
        logic [POS_BITS-1:0]   error_position;
        logic [CHECK_BITS-1:0] syndrome;
    } out_t;

    // bit i of each byte is element i of one 8-column group of a row
    localparam logic [7:0] GROUP [8] = '{
        8'hFF, 8'h64, 8'h92, 8'h09, 8'h08, 8'hC8, 8'h38, 8'h07
    };

    // row r of P: byte k is the group pattern rotated by r
    function automatic logic [DATA_BITS-1:0] row_mask(input logic [2:0] r);
        logic [DATA_BITS-1:0] m;
        logic [2:0]           idx;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            idx = 3'(k) - r;
            m[8*k +: 8] = GROUP[idx];
        end
        return m;
    endfunction

    // column of H at codeword position pos
    function automatic logic [CHECK_BITS-1:0] col_syn(input logic [POS_BITS-1:0] pos);
        logic [CHECK_BITS-1:0] s;
        logic [DATA_BITS-1:0]  m;
        logic [5:0]            j;
        s = '0;
        j = 6'(pos - POS_BITS'(CHECK_BITS));
        if (pos < POS_BITS'(CHECK_BITS)) begin
            s[pos[2:0]] = 1'b1;
        end else begin
            for (int r = 0; r < CHECK_BITS; r++) begin
                m    = row_mask(3'(r));
                s[r] = m[j];
            end
        end
        return s;
    endfunction

endpackage

// File: rtl/secded_core.sv
module secded_core (
    input  secded_pkg::in_t  word_in,
    output secded_pkg::out_t result
);
    import secded_pkg::*;

    logic [CHECK_BITS-1:0] syn;
    logic                  hit;
    logic [POS_BITS-1:0]   pos;
    logic [CODE_BITS-1:0]  flip;
    logic [CODE_BITS-1:0]  fixed;

    // syndrome: each row is its check bit plus parity over the masked data
    always_comb begin
        for (int r = 0; r < CHECK_BITS; r++) begin
            syn[r] = word_in.check_in[r] ^ (^(word_in.data_in & row_mask(3'(r))));
        end
    end

    // column match, lowest position wins
    always_comb begin
        hit = 1'b0;
        pos = '0;
        for (int p = CODE_BITS - 1; p >= 0; p--) begin
            if (syn == col_syn(POS_BITS'(p))) begin
                hit = 1'b1;
                pos = POS_BITS'(p);
            end
        end
    end

    assign flip  = hit ? (CODE_BITS'(1) << pos) : '0;
    assign fixed = {word_in.data_in, word_in.check_in} ^ flip;

    always_comb begin
        result.data_out       = fixed[CODE_BITS-1:CHECK_BITS];
        result.check_out      = fixed[CHECK_BITS-1:0];
        result.syndrome       = syn;
        result.error_position = hit ? pos : '0;
        if (syn == '0) begin
            result.status = STATUS_OK;
        end else if (hit) begin
            result.status = STATUS_CORRECTED;
        end else begin
            result.status = STATUS_UNCORRECTABLE;
        end
    end

endmodule

// File: rtl/secded_72_64_decoder.sv
// a word passes the input register, then the result register on m_valid;
// throughput: one 72-bit codeword per cycle unless m_ready stalls; the two
// registers bracket a single pass of syndrome, column match and bit flip
// reset: synchronous, active-low aresetn clears both valid flags; payload
// registers are not reset
module secded_72_64_decoder (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  secded_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output secded_pkg::out_t m_data
);
    import secded_pkg::*;

    // input stage
    logic in_valid_reg;
    logic in_valid_next;
    in_t  in_data_reg;

    // result stage
    logic out_valid_reg;
    logic out_valid_next;
    out_t out_data_reg;

    out_t core_result;
    logic out_load;     // result stage can take a new word this cycle
    logic in_take;      // input transfer this cycle

    // result stage frees up when empty or when its word leaves
    assign out_load = !out_valid_reg || m_ready;
    // input stage takes a word when empty or when its word moves on
    assign s_ready  = !in_valid_reg || out_load;
    assign in_take  = s_valid && s_ready;

    // decode logic sits between the two registers
    secded_core u_core (
        .word_in (in_data_reg),
        .result  (core_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_data_reg <= s_data;
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef ASSERT_OFF
    // a clean result always carries a zero syndrome
    a_ok_zero_syn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_OK |-> m_data.syndrome == '0)
        else $error("no-error result with nonzero syndrome");

    // a corrected position lies inside the codeword
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_CORRECTED
        |-> m_data.error_position < POS_BITS'(CODE_BITS))
        else $error("corrected position outside codeword");

    // a corrected check bit has a single-bit syndrome
    a_check_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_CORRECTED
        && m_data.error_position < POS_BITS'(CHECK_BITS)
        |-> $onehot(m_data.syndrome))
        else $error("check-bit correction without single-bit syndrome");

    // position is zero unless a bit was corrected
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_CORRECTED |-> m_data.error_position == '0)
        else $error("error position set without correction");

    // a held input word survives a stall of the result stage
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage lost a word during a stall");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

import secded_pkg::*;

// expected decoder results, computed from the code's own matrix
class ecc_scoreboard;
    logic [7:0][7:0]  group_pat;
    logic [7:0][63:0] row_masks;
    logic [71:0][7:0] h_columns;
    out_t             expected_words[$];
    int               errors;
    int               checked;
    int               seen_clean;
    int               seen_fixed;
    int               seen_bad;

    function new();
        errors     = 0;
        checked    = 0;
        seen_clean = 0;
        seen_fixed = 0;
        seen_bad   = 0;
        group_pat  = {8'h07, 8'h38, 8'hC8, 8'h08, 8'h09, 8'h92, 8'h64, 8'hFF};
        // row r: byte k holds the group pattern rotated by r
        for (int r = 0; r < 8; r++) begin
            for (int k = 0; k < 8; k++) begin
                row_masks[r][8*k +: 8] = group_pat[(k - r) & 7];
            end
        end
        // identity part for the check bits, then the data columns of P
        for (int p = 0; p < CHECK_BITS; p++) begin
            h_columns[p]    = '0;
            h_columns[p][p] = 1'b1;
        end
        for (int j = 0; j < DATA_BITS; j++) begin
            for (int r = 0; r < CHECK_BITS; r++) begin
                h_columns[CHECK_BITS + j][r] = row_masks[r][j];
            end
        end
    endfunction

    function logic [7:0] data_parity(logic [63:0] d);
        logic [7:0] p;
        for (int r = 0; r < CHECK_BITS; r++) begin
            p[r] = ^(d & row_masks[r]);
        end
        return p;
    endfunction

    function out_t decode_word(in_t w);
        out_t        r;
        logic [7:0]  syn;
        logic [71:0] cw;
        logic        found;
        syn              = w.check_in ^ data_parity(w.data_in);
        r.data_out       = w.data_in;
        r.check_out      = w.check_in;
        r.status         = STATUS_OK;
        r.error_position = '0;
        r.syndrome       = syn;
        found            = 1'b0;
        if (syn != 8'h00) begin
            r.status = STATUS_UNCORRECTABLE;
            for (int p = 0; p < CODE_BITS; p++) begin
                if (!found && h_columns[p] == syn) begin
                    found            = 1'b1;
                    cw               = {w.data_in, w.check_in};
                    cw[p]            = ~cw[p];
                    r.data_out       = cw[71:8];
                    r.check_out      = cw[7:0];
                    r.status         = STATUS_CORRECTED;
                    r.error_position = 7'(p);
                end
            end
        end
        return r;
    endfunction

    function void note_codeword(in_t w);
        expected_words.push_back(decode_word(w));
    endfunction

    function void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    function void check_decoded(out_t got);
        out_t want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected result", '0, got.data_out);
            return;
        end
        want = expected_words.pop_front();
        checked++;
        case (want.status)
            STATUS_OK:        seen_clean++;
            STATUS_CORRECTED: seen_fixed++;
            default:          seen_bad++;
        endcase
        if (got.data_out !== want.data_out)
            report_mismatch("data_out", want.data_out, got.data_out);
        if (got.check_out !== want.check_out)
            report_mismatch("check_out", 64'(want.check_out), 64'(got.check_out));
        if (got.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.error_position !== want.error_position)
            report_mismatch("error_position", 64'(want.error_position),
                            64'(got.error_position));
        if (got.syndrome !== want.syndrome)
            report_mismatch("syndrome", 64'(want.syndrome), 64'(got.syndrome));
    endfunction
endclass

module testbench;
    localparam int LIMIT        = 200000;
    localparam int RANDOM_ITEMS = 700;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    ecc_scoreboard ledger;
    int            cycles    = 0;
    int            rx_tick   = 0;
    int            stall_left = 0;
    int            burst_left = 0;
    bit            gaps_on   = 1'b1;

    secded_72_64_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock, first rising edge at 5 ns
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // transfers on both channels are observed at the rising edge,
    // before any register in the block updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                ledger.note_codeword(s_data);
            if (m_valid && m_ready)
                ledger.check_decoded(m_data);
        end
    end

    // watchdog against a hung handshake
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, ledger.expected_words.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver back-pressure: rotates through always ready, coin-flip,
    // a fixed repeating pattern and occasional long stalls
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        case ((rx_tick / 250) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ((rx_tick % 7) < 4);
            default: begin
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    m_ready    <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left <= $urandom_range(3, 12);
                    m_ready    <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // codeword with check bits that give a zero syndrome
    function automatic in_t make_codeword(logic [63:0] d);
        in_t w;
        w.data_in  = d;
        w.check_in = ledger.data_parity(d);
        return w;
    endfunction

    // invert one codeword position (0..7 check bits, 8..71 data bits)
    function automatic in_t flip_position(in_t w, int p);
        logic [71:0] v;
        v    = w;
        v[p] = ~v[p];
        return in_t'(v);
    endfunction

    // hold valid high with the payload until the transfer happens
    task automatic send_codeword(in_t w);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, then wait out the requested pause
    task automatic pause_sender(int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // bursts of random length with random gaps between them
    task automatic paced_send(in_t w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                pause_sender($urandom_range(1, 8));
        end
        burst_left--;
        send_codeword(w);
    endtask

    // mostly valid codewords with single, double and triple errors, some noise
    function automatic in_t random_word();
        in_t w;
        int  kind;
        int  a;
        w    = make_codeword({$urandom, $urandom});
        kind = $urandom_range(0, 99);
        a    = $urandom_range(0, CODE_BITS - 1);
        if (kind < 40) begin
            // clean codeword
        end else if (kind < 75) begin
            w = flip_position(w, a);
        end else if (kind < 90) begin
            w = flip_position(w, a);
            w = flip_position(w, (a + $urandom_range(1, CODE_BITS - 1)) % CODE_BITS);
        end else if (kind < 95) begin
            // three flips: may alias to a column and be miscorrected
            w = flip_position(w, a);
            w = flip_position(w, (a + 1 + $urandom_range(0, 34)) % CODE_BITS);
            w = flip_position(w, (a + 36 + $urandom_range(0, 34)) % CODE_BITS);
        end else begin
            w.data_in  = {$urandom, $urandom};
            w.check_in = 8'($urandom_range(0, 255));
        end
        return w;
    endfunction

    initial begin
        in_t directed[$];
        in_t w;

        ledger = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: clean words at the data extremes
        directed.push_back(make_codeword(64'h0));
        directed.push_back(make_codeword({64{1'b1}}));
        directed.push_back(make_codeword(64'hAAAA_AAAA_AAAA_AAAA));
        directed.push_back(make_codeword(64'h5555_5555_5555_5555));
        // single errors at the ends of the check and data fields and inside them
        directed.push_back(flip_position(make_codeword(64'h0), 0));
        directed.push_back(flip_position(make_codeword(64'h0), 7));
        directed.push_back(flip_position(make_codeword(64'h0), 8));
        directed.push_back(flip_position(make_codeword(64'h0), 71));
        directed.push_back(flip_position(make_codeword({64{1'b1}}), 3));
        directed.push_back(flip_position(make_codeword({64{1'b1}}), 40));
        directed.push_back(flip_position(make_codeword({64{1'b1}}), 71));
        // double errors: check/check, data/data, check/data boundary
        w = flip_position(make_codeword(64'h0), 0);
        directed.push_back(flip_position(w, 1));
        w = flip_position(make_codeword(64'h0), 8);
        directed.push_back(flip_position(w, 71));
        w = flip_position(make_codeword({64{1'b1}}), 7);
        directed.push_back(flip_position(w, 8));
        // triple error in adjacent data bits
        w = flip_position(make_codeword(64'h0123_4567_89AB_CDEF), 8);
        w = flip_position(w, 9);
        directed.push_back(flip_position(w, 10));
        // raw: all ones, syndrome FF, two check bits, data ends plus check 7
        directed.push_back(in_t'({72{1'b1}}));
        directed.push_back(in_t'({64'h0, 8'hFF}));
        directed.push_back(in_t'({64'h0, 8'h03}));
        directed.push_back(in_t'({64'h8000_0000_0000_0001, 8'h80}));

        foreach (directed[i])
            paced_send(directed[i]);

        // random part, with a stretch of back-to-back transfers in the middle
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gaps_on = !(i >= 250 && i < 350);
            paced_send(random_word());
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then allow the pipeline latency to pass
        while (ledger.expected_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("decoded %0d words: %0d clean, %0d corrected, %0d uncorrectable",
                 ledger.checked, ledger.seen_clean, ledger.seen_fixed, ledger.seen_bad);
        $display("bursty sender and mixed back-pressure over %0d cycles, %0d mismatches",
                 cycles, ledger.errors);
        if (ledger.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/secded_pkg.sv
rtl/secded_core.sv
rtl/secded_72_64_decoder.sv
tb/testbench.sv
